### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the point-on-segment ratio block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define POSR_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define POSR_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/posr_pkg.sv
// Package of the point-on-segment ratio block: beat types, status codes and
// the fixed widths and latencies. No dependencies.
package posr_pkg;

	localparam int IN_W            = 32;
	localparam int TOL_BITS        = 16;
	localparam int RATIO_W         = 17;
	localparam int STEP_BITS       = 2;
	localparam int DIV_LAT         = 1 + (RATIO_W + STEP_BITS - 1) / STEP_BITS;
	localparam int CHK_LAT         = 4;
	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd3277;
	localparam logic [RATIO_W-1:0]  RATIO_ONE = 17'h10000;

	typedef enum logic [1:0] {
		ST_ON    = 2'd0,
		ST_DEGEN = 2'd1,
		ST_FAR   = 2'd2
	} posr_status_e;

	typedef struct packed {
		logic signed [IN_W-1:0] ax;
		logic signed [IN_W-1:0] ay;
		logic signed [IN_W-1:0] bx;
		logic signed [IN_W-1:0] by;
		logic signed [IN_W-1:0] px;
		logic signed [IN_W-1:0] py;
	} posr_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [RATIO_W-1:0] ratio;
	} posr_out_t;

	// Which distance test applies to an item.
	typedef struct packed {
		logic deg;
		logic mid;
	} posr_cls_t;

endpackage

### rtl/core/posr_front.sv
// Front end: coordinate differences, products, dot/cross/length sums and the
// choice of distance test. Depends on posr_pkg.
module posr_front import posr_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                        clk,
	input  logic                        en,
	input  posr_in_t                    item,
	output logic [2*COORD_WIDTH+1:0]    l2_s3,
	output logic [2*COORD_WIDTH+1:0]    uu_s3,
	output logic [2*COORD_WIDTH+1:0]    vv_s3,
	output logic [2*COORD_WIDTH+1:0]    m_s4,
	output logic [2*COORD_WIDTH+1:0]    l2_s4,
	output posr_cls_t                   cls_s4
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int W2 = 2 * DW;

	logic signed [DW-1:0] ax, ay, bx, by, px, py;
	logic signed [DW-1:0] dx_s1, dy_s1, ux_s1, uy_s1, vx_s1, vy_s1;
	logic                 deg_s1, deg_s2, deg_s3;
	logic signed [W2-1:0] dxx_s2, dyy_s2, udx_s2, udy_s2, uxx_s2, uyy_s2;
	logic signed [W2-1:0] vxx_s2, vyy_s2, uxdy_s2, uydx_s2;
	logic signed [W2-1:0] dot_s3, cross_s3;
	logic                 dot_le0, dot_gt;
	logic [W2-1:0]        cross_mag;

	assign ax = DW'($signed(item.ax[COORD_WIDTH-1:0]));
	assign ay = DW'($signed(item.ay[COORD_WIDTH-1:0]));
	assign bx = DW'($signed(item.bx[COORD_WIDTH-1:0]));
	assign by = DW'($signed(item.by[COORD_WIDTH-1:0]));
	assign px = DW'($signed(item.px[COORD_WIDTH-1:0]));
	assign py = DW'($signed(item.py[COORD_WIDTH-1:0]));

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= bx - ax;
			dy_s1  <= by - ay;
			ux_s1  <= px - ax;
			uy_s1  <= py - ay;
			vx_s1  <= px - bx;
			vy_s1  <= py - by;
			deg_s1 <= (ax == bx) && (ay == by);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			udx_s2  <= ux_s1 * dx_s1;
			udy_s2  <= uy_s1 * dy_s1;
			uxx_s2  <= ux_s1 * ux_s1;
			uyy_s2  <= uy_s1 * uy_s1;
			vxx_s2  <= vx_s1 * vx_s1;
			vyy_s2  <= vy_s1 * vy_s1;
			uxdy_s2 <= ux_s1 * dy_s1;
			uydx_s2 <= uy_s1 * dx_s1;
			deg_s2  <= deg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s3    <= $unsigned(dxx_s2 + dyy_s2);
			uu_s3    <= $unsigned(uxx_s2 + uyy_s2);
			vv_s3    <= $unsigned(vxx_s2 + vyy_s2);
			dot_s3   <= udx_s2 + udy_s2;
			cross_s3 <= uxdy_s2 - uydx_s2;
			deg_s3   <= deg_s2;
		end
	end

	// Nearest point is A when the projection falls before it, B when past it.
	assign dot_le0   = dot_s3[W2-1] || (dot_s3 == '0);
	assign dot_gt    = !dot_le0 && ($unsigned(dot_s3) > l2_s3);
	assign cross_mag = cross_s3[W2-1] ? $unsigned(-cross_s3) : $unsigned(cross_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4       <= dot_le0 ? uu_s3 : (dot_gt ? vv_s3 : cross_mag);
			l2_s4      <= l2_s3;
			cls_s4.mid <= !dot_le0 && !dot_gt;
			cls_s4.deg <= deg_s3;
		end
	end

endmodule

### rtl/core/posr_isqrt.sv
// Pipelined floor square root, a fixed number of result bits per stage.
// Depends on posr_pkg.
module posr_isqrt import posr_pkg::*; #(
	parameter int RW = DEF_COORD_WIDTH + 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	localparam int NST = (RW + STEP_BITS - 1) / STEP_BITS;

	logic [RW+1:0]   rem_s  [NST-1];
	logic [2*RW-1:0] rad_s  [NST-1];
	logic [RW-1:0]   root_s [NST];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic [RW+1:0]   r_in, r_nx;
		logic [RW-1:0]   q_in, q_nx;
		logic [2*RW-1:0] n_in, n_nx;

		if (s == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign n_in = rad;
		end else begin : g_next
			assign r_in = rem_s[s-1];
			assign q_in = root_s[s-1];
			assign n_in = rad_s[s-1];
		end

		always_comb begin
			logic [RW+3:0] t;
			logic [RW+3:0] trial;
			r_nx = r_in;
			q_nx = q_in;
			n_nx = n_in;
			for (int j = 0; j < STEP_BITS; j++) begin
				t     = '0;
				trial = '0;
				if (s * STEP_BITS + j < RW) begin
					t     = {r_nx, n_nx[2*RW-1 -: 2]};
					trial = (RW + 4)'({q_nx, 2'b01});
					n_nx  = n_nx << 2;
					if (t >= trial) begin
						r_nx = (RW + 2)'(t - trial);
						q_nx = {q_nx[RW-2:0], 1'b1};
					end else begin
						r_nx = (RW + 2)'(t);
						q_nx = {q_nx[RW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[s] <= q_nx;
			end
		end

		if (s < NST - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[s] <= r_nx;
					rad_s[s] <= n_nx;
				end
			end
		end
	end

	assign root = root_s[NST-1];

endmodule

### rtl/core/posr_wmul.sv
// Two-stage wide unsigned multiplier built from four half-width products.
// Depends on posr_pkg.
module posr_wmul import posr_pkg::*; #(
	parameter int AW = 2 * (DEF_COORD_WIDTH + 1),
	parameter int BW = 2 * (DEF_COORD_WIDTH + 1)
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= (AL + BL)'(a[AL-1:0]) * (AL + BL)'(b[BL-1:0]);
			lh_s1 <= (AL + BH)'(a[AL-1:0]) * (AL + BH)'(b[BW-1:BL]);
			hl_s1 <= (AH + BL)'(a[AW-1:AL]) * (AH + BL)'(b[BL-1:0]);
			hh_s1 <= (AH + BH)'(a[AW-1:AL]) * (AH + BH)'(b[BW-1:BL]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
				+ (PW'(hh_s1) << (AL + BL));
		end
	end

	assign p = p_s2;

endmodule

### rtl/core/posr_check.sv
// Distance test: scales the tolerance by the segment length and compares it
// with the squared distance. Depends on posr_pkg and posr_wmul.
module posr_check import posr_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [TOL_BITS-1:0]        tol,
	input  logic [COORD_WIDTH:0]       len,
	input  logic [2*COORD_WIDTH+1:0]   m,
	input  logic [2*COORD_WIDTH+1:0]   l2,
	input  posr_cls_t                  cls,
	output posr_status_e               status
);

	localparam int RW   = COORD_WIDTH + 1;
	localparam int W2   = 2 * RW;
	localparam int TW   = TOL_BITS + RW;
	localparam int CMPW = 2 * W2 + TOL_BITS + FRAC_BITS;

	logic [TW-1:0]      t_s1, t_s2, t_s3;
	logic [W2-1:0]      l2_s1, m_s1, m_s2, m_s3;
	posr_cls_t          cls_s1, cls_s2, cls_s3;
	logic [2*W2-1:0]    mm, mm_s3;
	logic [TW+W2-1:0]   tl;
	logic [CMPW-1:0]    lhs, rhs;
	posr_status_e       status_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= TW'(tol) * TW'(len);
			l2_s1  <= l2;
			m_s1   <= m;
			cls_s1 <= cls;
			t_s2   <= t_s1;
			m_s2   <= m_s1;
			cls_s2 <= cls_s1;
			t_s3   <= t_s2;
			m_s3   <= m_s2;
			cls_s3 <= cls_s2;
			mm_s3  <= mm;
		end
	end

	posr_wmul #(.AW(W2), .BW(W2)) u_sq (
		.clk (clk),
		.en  (en),
		.a   (m),
		.b   (m),
		.p   (mm)
	);

	posr_wmul #(.AW(TW), .BW(W2)) u_tl (
		.clk (clk),
		.en  (en),
		.a   (t_s1),
		.b   (l2_s1),
		.p   (tl)
	);

	// The perpendicular case compares squares; both sides carry an extra L2.
	assign lhs = CMPW'(cls_s3.mid ? mm_s3 : (2 * W2)'(m_s3)) << TOL_BITS;
	assign rhs = CMPW'(cls_s3.mid ? tl : (TW + W2)'(t_s3)) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			if (cls_s3.deg) begin
				status_s4 <= ST_DEGEN;
			end else if (lhs > rhs) begin
				status_s4 <= ST_FAR;
			end else begin
				status_s4 <= ST_ON;
			end
		end
	end

	assign status = status_s4;

endmodule

### rtl/core/posr_div.sv
// Pipelined restoring divider for pa * 2^16 / (pa + pb).
// Depends on posr_pkg.
module posr_div import posr_pkg::*; #(
	parameter int RW = DEF_COORD_WIDTH + 1
) (
	input  logic               clk,
	input  logic               en,
	input  logic [RW-1:0]      pa,
	input  logic [RW-1:0]      pb,
	output logic [RATIO_W-1:0] ratio
);

	localparam int NDS = (RATIO_W + STEP_BITS - 1) / STEP_BITS;

	logic [RW:0]          dsum_s1;
	logic [RW+1:0]        rem0_s1;
	logic [RW+1:0]        rem_s [NDS-1];
	logic [RW:0]          den_s [NDS];
	logic [RATIO_W-1:0]   quo_s [NDS];

	always_ff @(posedge clk) begin
		if (en) begin
			dsum_s1 <= (RW + 1)'(pa) + (RW + 1)'(pb);
			rem0_s1 <= (RW + 2)'(pa);
		end
	end

	for (genvar s = 0; s < NDS; s++) begin : g_st
		logic [RW+1:0]      r_in, r_nx;
		logic [RW:0]        d_in;
		logic [RATIO_W-1:0] q_in, q_nx;

		if (s == 0) begin : g_first
			assign r_in = rem0_s1;
			assign d_in = dsum_s1;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[s-1];
			assign d_in = den_s[s-1];
			assign q_in = quo_s[s-1];
		end

		always_comb begin
			r_nx = r_in;
			q_nx = q_in;
			for (int j = 0; j < STEP_BITS; j++) begin
				if (s * STEP_BITS + j < RATIO_W) begin
					if (r_nx >= (RW + 2)'(d_in)) begin
						r_nx = r_nx - (RW + 2)'(d_in);
						q_nx = {q_nx[RATIO_W-2:0], 1'b1};
					end else begin
						q_nx = {q_nx[RATIO_W-2:0], 1'b0};
					end
					r_nx = r_nx << 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[s] <= d_in;
				quo_s[s] <= q_nx;
			end
		end

		if (s < NDS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[s] <= r_nx;
				end
			end
		end
	end

	assign ratio = (den_s[NDS-1] == '0) ? '0 : quo_s[NDS-1];

endmodule

### rtl/core/point_on_segment_ratio_top.sv
// Point-on-segment ratio block, top level.
// Uses posr_pkg, posr_front, posr_isqrt, posr_check, posr_div, assert_macros.svh.
//
// Usage. Each input beat on item carries segment end points A and B and a
// query point P as signed fixed-point coordinates. Each beat gives exactly one
// result beat on res: status 0 with ratio |PA|/(|PA|+|PB|) in Q1.16, status 1
// for a degenerate segment, or status 2 when P lies too far from the segment.
// The tolerance register is written through cfg_we and cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not
// enforce. It resets to 3277. The datapath is one pipeline that takes a new
// beat every cycle while the output does not stall; the three square roots,
// two result bits per stage, form its longest part, and the quotient takes a
// further ten stages.
// When the receiver stalls while a result beat is held, the whole pipeline
// freezes and item_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits of every stage and the output valid bit.
module point_on_segment_ratio_top import posr_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  posr_in_t            item,
	output logic                res_valid,
	input  logic                res_stall,
	output posr_out_t           res,
	input  logic                cfg_we,
	input  logic [TOL_BITS-1:0] cfg_wdata
);

	localparam int RW   = COORD_WIDTH + 1;
	localparam int W2   = 2 * RW;
	localparam int LSQ  = (RW + STEP_BITS - 1) / STEP_BITS;
	localparam int PIPE = 3 + LSQ + DIV_LAT;
	localparam int SDLY = DIV_LAT - CHK_LAT;

	logic                en;
	logic [TOL_BITS-1:0] tol_q;
	logic                vld_s [PIPE];
	logic                res_vld_q;
	posr_out_t           res_q;

	logic [W2-1:0]       f_l2, f_uu, f_vv, f_m, f_l2c;
	posr_cls_t           f_cls;
	logic [RW-1:0]       len, pa, pb;
	logic [W2-1:0]       dm_s [LSQ-1];
	logic [W2-1:0]       dl_s [LSQ-1];
	posr_cls_t           dc_s [LSQ-1];
	posr_status_e        chk_status;
	posr_status_e        st_s [SDLY];
	logic [RATIO_W-1:0]  div_ratio;

	// A held result that the receiver refuses freezes every stage.
	assign en         = !(res_vld_q && res_stall);
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Valid bits move alongside the data, one per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE; i++) begin
				vld_s[i] <= 1'b0;
			end
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= item_valid;
			for (int i = 1; i < PIPE; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			res_vld_q <= vld_s[PIPE-1];
		end
	end

	posr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk    (clk),
		.en     (en),
		.item   (item),
		.l2_s3  (f_l2),
		.uu_s3  (f_uu),
		.vv_s3  (f_vv),
		.m_s4   (f_m),
		.l2_s4  (f_l2c),
		.cls_s4 (f_cls)
	);

	// Segment length and the two distances to the end points.
	posr_isqrt #(.RW(RW)) u_len (.clk(clk), .en(en), .rad(f_l2), .root(len));
	posr_isqrt #(.RW(RW)) u_pa  (.clk(clk), .en(en), .rad(f_uu), .root(pa));
	posr_isqrt #(.RW(RW)) u_pb  (.clk(clk), .en(en), .rad(f_vv), .root(pb));

	// The distance operands wait for the segment length to come out.
	always_ff @(posedge clk) begin
		if (en) begin
			dm_s[0] <= f_m;
			dl_s[0] <= f_l2c;
			dc_s[0] <= f_cls;
			for (int i = 1; i < LSQ - 1; i++) begin
				dm_s[i] <= dm_s[i-1];
				dl_s[i] <= dl_s[i-1];
				dc_s[i] <= dc_s[i-1];
			end
		end
	end

	posr_check #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_check (
		.clk    (clk),
		.en     (en),
		.tol    (tol_q),
		.len    (len),
		.m      (dm_s[LSQ-2]),
		.l2     (dl_s[LSQ-2]),
		.cls    (dc_s[LSQ-2]),
		.status (chk_status)
	);

	posr_div #(.RW(RW)) u_div (
		.clk   (clk),
		.en    (en),
		.pa    (pa),
		.pb    (pb),
		.ratio (div_ratio)
	);

	// The status is ready before the quotient and waits for it here.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= chk_status;
			for (int i = 1; i < SDLY; i++) begin
				st_s[i] <= st_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.status <= st_s[SDLY-1];
			res_q.ratio  <= (st_s[SDLY-1] == ST_ON) ? div_ratio : '0;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

`include "assert_macros.svh"

	`POSR_CHECK(a_reject_zero, res_vld_q && res_q.status != ST_ON, res_q.ratio == '0, "rejected beat with a non-zero ratio")
	`POSR_CHECK(a_ratio_range, res_vld_q && res_q.status == ST_ON, res_q.ratio <= RATIO_ONE, "ratio above one")
	`POSR_CHECK_NEXT(a_freeze, res_vld_q && res_stall, vld_s[PIPE-1] == $past(vld_s[PIPE-1]), "pipeline moved while frozen")

endmodule
